@@ design/uft_pkg.sv @@
// Shared types and fold functions for the UTF-8 fold tokenizer.
// Used by the front, queue and back modules; no dependencies.
package uft_pkg;

   localparam int SlotCount = 5;
   localparam int CountWidth = 3;
   localparam int SlotIdxWidth = 3;
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = 1;

   localparam logic [1:0] ActNone = 2'd0;
   localparam logic [1:0] ActSep = 2'd1;
   localparam logic [1:0] ActBytes = 2'd2;

   localparam logic [20:0] ReplCp = 21'h00FFFD;

   typedef struct packed {
      logic [7:0] data;
      logic token_end;
   } slot_type;

   typedef struct packed {
      slot_type [SlotCount-1:0] slots;
      logic [CountWidth-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic [2:0] count;
      logic [3:0][7:0] bytes;
   } cp_act_type;

   function automatic logic in_rng(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic cp_act_type one_byte(logic [7:0] b);
      cp_act_type r;
      r = '0;
      r.act = ActBytes;
      r.count = 3'd1;
      r.bytes[0] = b;
      return r;
   endfunction

   function automatic cp_act_type sep_act();
      cp_act_type r;
      r = '0;
      r.act = ActSep;
      return r;
   endfunction

   // Text of one or two ASCII letters; a one-letter text has a zero upper byte.
   function automatic cp_act_type fold_txt(logic [15:0] t);
      cp_act_type r;
      r = '0;
      r.act = ActBytes;
      if (t[15:8] == 8'h00) begin
         r.count = 3'd1;
         r.bytes[0] = t[7:0];
      end else begin
         r.count = 3'd2;
         r.bytes[0] = t[15:8];
         r.bytes[1] = t[7:0];
      end
      return r;
   endfunction

   function automatic cp_act_type encode_utf8(logic [16:0] c);
      cp_act_type r;
      r = '0;
      r.act = ActBytes;
      if (c < 17'h00080) begin
         r.count = 3'd1;
         r.bytes[0] = {1'b0, c[6:0]};
      end else if (c < 17'h00800) begin
         r.count = 3'd2;
         r.bytes[0] = {3'b110, c[10:6]};
         r.bytes[1] = {2'b10, c[5:0]};
      end else if (c < 17'h10000) begin
         r.count = 3'd3;
         r.bytes[0] = {4'b1110, c[15:12]};
         r.bytes[1] = {2'b10, c[11:6]};
         r.bytes[2] = {2'b10, c[5:0]};
      end else begin
         r.count = 3'd4;
         r.bytes[0] = 8'hF0;
         r.bytes[1] = {3'b100, c[16:12]};
         r.bytes[2] = {2'b10, c[11:6]};
         r.bytes[3] = {2'b10, c[5:0]};
      end
      return r;
   endfunction

   // ASCII folds for U+00C0..U+017F; the multiply and divide signs separate.
   function automatic cp_act_type latin_fold(logic [8:0] c);
      cp_act_type r;
      if (c <= 9'h0C5) r = fold_txt(16'h0061);
      else if (c <= 9'h0C6) r = fold_txt(16'h6165);
      else if (c <= 9'h0C7) r = fold_txt(16'h0063);
      else if (c <= 9'h0CB) r = fold_txt(16'h0065);
      else if (c <= 9'h0CF) r = fold_txt(16'h0069);
      else if (c <= 9'h0D0) r = fold_txt(16'h0064);
      else if (c <= 9'h0D1) r = fold_txt(16'h006E);
      else if (c <= 9'h0D6) r = fold_txt(16'h006F);
      else if (c <= 9'h0D7) r = sep_act();
      else if (c <= 9'h0D8) r = fold_txt(16'h006F);
      else if (c <= 9'h0DC) r = fold_txt(16'h0075);
      else if (c <= 9'h0DD) r = fold_txt(16'h0079);
      else if (c <= 9'h0DE) r = fold_txt(16'h7468);
      else if (c <= 9'h0DF) r = fold_txt(16'h7373);
      else if (c <= 9'h0E5) r = fold_txt(16'h0061);
      else if (c <= 9'h0E6) r = fold_txt(16'h6165);
      else if (c <= 9'h0E7) r = fold_txt(16'h0063);
      else if (c <= 9'h0EB) r = fold_txt(16'h0065);
      else if (c <= 9'h0EF) r = fold_txt(16'h0069);
      else if (c <= 9'h0F0) r = fold_txt(16'h0064);
      else if (c <= 9'h0F1) r = fold_txt(16'h006E);
      else if (c <= 9'h0F6) r = fold_txt(16'h006F);
      else if (c <= 9'h0F7) r = sep_act();
      else if (c <= 9'h0F8) r = fold_txt(16'h006F);
      else if (c <= 9'h0FC) r = fold_txt(16'h0075);
      else if (c <= 9'h0FD) r = fold_txt(16'h0079);
      else if (c <= 9'h0FE) r = fold_txt(16'h7468);
      else if (c <= 9'h0FF) r = fold_txt(16'h0079);
      else if (c <= 9'h105) r = fold_txt(16'h0061);
      else if (c <= 9'h10D) r = fold_txt(16'h0063);
      else if (c <= 9'h111) r = fold_txt(16'h0064);
      else if (c <= 9'h11B) r = fold_txt(16'h0065);
      else if (c <= 9'h123) r = fold_txt(16'h0067);
      else if (c <= 9'h127) r = fold_txt(16'h0068);
      else if (c <= 9'h131) r = fold_txt(16'h0069);
      else if (c <= 9'h133) r = fold_txt(16'h696A);
      else if (c <= 9'h135) r = fold_txt(16'h006A);
      else if (c <= 9'h138) r = fold_txt(16'h006B);
      else if (c <= 9'h142) r = fold_txt(16'h006C);
      else if (c <= 9'h149) r = fold_txt(16'h006E);
      else if (c <= 9'h14B) r = fold_txt(16'h6E67);
      else if (c <= 9'h151) r = fold_txt(16'h006F);
      else if (c <= 9'h153) r = fold_txt(16'h6F65);
      else if (c <= 9'h159) r = fold_txt(16'h0072);
      else if (c <= 9'h161) r = fold_txt(16'h0073);
      else if (c <= 9'h167) r = fold_txt(16'h0074);
      else if (c <= 9'h173) r = fold_txt(16'h0075);
      else if (c <= 9'h175) r = fold_txt(16'h0077);
      else if (c <= 9'h178) r = fold_txt(16'h0079);
      else if (c <= 9'h17E) r = fold_txt(16'h007A);
      else r = fold_txt(16'h0073);
      return r;
   endfunction

   function automatic logic [10:0] greek_lower(logic [10:0] c);
      logic [10:0] r;
      r = c;
      if (c == 11'h386) r = 11'h3AC;
      else if (c >= 11'h388 && c <= 11'h38A) r = c + 11'h025;
      else if (c == 11'h38C) r = 11'h3CC;
      else if (c >= 11'h38E && c <= 11'h38F) r = c + 11'h03F;
      else if ((c >= 11'h391 && c <= 11'h3A1) || (c >= 11'h3A3 && c <= 11'h3AB))
         r = c + 11'h020;
      return r;
   endfunction

   function automatic logic [10:0] cyr_lower(logic [10:0] c);
      logic [10:0] r;
      r = c;
      if (c >= 11'h400 && c <= 11'h40F) r = c + 11'h050;
      else if (c >= 11'h410 && c <= 11'h42F) r = c + 11'h020;
      else if ((c >= 11'h460 && c <= 11'h481) || (c >= 11'h48A && c <= 11'h4BF))
         r = c[0] ? c : c + 11'h001;
      return r;
   endfunction

   function automatic logic is_dropped_cp(logic [20:0] c);
      return c == 21'h00AD || in_rng(c, 21'h0300, 21'h036F) || in_rng(c, 21'h1AB0, 21'h1AFF)
         || in_rng(c, 21'h1DC0, 21'h1DFF) || in_rng(c, 21'h200B, 21'h200D)
         || in_rng(c, 21'h20D0, 21'h20FF) || in_rng(c, 21'hFE00, 21'hFE0F)
         || in_rng(c, 21'hFE20, 21'hFE2F);
   endfunction

   function automatic logic is_symbol_sep(logic [20:0] c);
      logic r;
      if (in_rng(c, 21'h00A1, 21'h00BF)) r = (c != 21'h00AA) && (c != 21'h00BA);
      else r = in_rng(c, 21'h0080, 21'h00A0) || in_rng(c, 21'h02B0, 21'h02FF)
         || in_rng(c, 21'h2000, 21'h20CF) || in_rng(c, 21'h2100, 21'h2BFF)
         || in_rng(c, 21'h2E00, 21'h2E7F) || in_rng(c, 21'h3000, 21'h303F)
         || in_rng(c, 21'hD800, 21'hDFFF) || in_rng(c, 21'hFE10, 21'hFE6F)
         || in_rng(c, 21'hFFF0, 21'hFFFF) || (c >= 21'h1F000);
      return r;
   endfunction

   // What one decoded code point turns into: nothing, a separator or folded bytes.
   function automatic cp_act_type classify(logic [20:0] c);
      cp_act_type r;
      r = '0;
      if (c < 21'h80) begin
         if (in_rng(c, 21'h30, 21'h39) || in_rng(c, 21'h61, 21'h7A)) r = one_byte(c[7:0]);
         else if (in_rng(c, 21'h41, 21'h5A)) r = one_byte(c[7:0] + 8'h20);
         else r = sep_act();
      end else if (is_dropped_cp(c)) begin
         r.act = ActNone;
      end else if (is_symbol_sep(c)) begin
         r = sep_act();
      end else if (c == 21'h00AA) begin
         r = one_byte(8'h61);
      end else if (c == 21'h00BA) begin
         r = one_byte(8'h6F);
      end else if (in_rng(c, 21'h00C0, 21'h017F)) begin
         r = latin_fold(c[8:0]);
      end else if (in_rng(c, 21'hFF10, 21'hFF19)) begin
         r = one_byte(c[7:0] + 8'h20);
      end else if (in_rng(c, 21'hFF21, 21'hFF3A)) begin
         r = one_byte(c[7:0] + 8'h40);
      end else if (in_rng(c, 21'hFF41, 21'hFF5A)) begin
         r = one_byte(c[7:0] + 8'h20);
      end else if (in_rng(c, 21'hFF01, 21'hFF20) || in_rng(c, 21'hFF3B, 21'hFF40)
                   || in_rng(c, 21'hFF5B, 21'hFF65)) begin
         r = sep_act();
      end else if (in_rng(c, 21'h0370, 21'h03FF)) begin
         r = encode_utf8({6'd0, greek_lower(c[10:0])});
      end else if (in_rng(c, 21'h0400, 21'h04FF)) begin
         r = encode_utf8({6'd0, cyr_lower(c[10:0])});
      end else begin
         r = encode_utf8(c[16:0]);
      end
      return r;
   endfunction

endpackage

@@ design/uft_req_if.sv @@
// Input channel of the tokenizer: one text byte and its end-of-text flag.
// Depends on nothing.
interface uft_req_if;
   logic valid;
   logic ready;
   logic [7:0] text_byte;
   logic final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

@@ design/uft_rsp_if.sv @@
// Result channel of the tokenizer: one folded byte or a token end.
// Depends on nothing.
interface uft_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] folded_byte;
   logic token_end;
   logic run_last;

   modport source (output valid, output folded_byte, output token_end, output run_last,
                   input ready);
   modport sink (input valid, input folded_byte, input token_end, input run_last,
                 output ready);
endinterface

@@ design/uft_front.sv @@
// Front end: UTF-8 decoder, code point classifier and result list builder.
// Depends on uft_pkg.
module uft_front (
   input  logic clock,
   input  logic reset,
   input  logic in_fire,
   input  logic [7:0] in_byte,
   input  logic in_final,
   output logic push,
   output uft_pkg::cmd_type cmd
);

   logic [1:0] need_ff, need_in;
   logic [1:0] seen_ff, seen_in;
   logic [20:0] accum_ff, accum_in;
   logic open_ff, open_in;

   logic pre_sep, lead_sep, cp_valid;
   logic [20:0] cp;
   logic [20:0] acc_next;
   logic [1:0] seen_next;
   uft_pkg::cp_act_type act;
   logic [uft_pkg::CountWidth-1:0] n;
   logic open_w;

   always_comb begin
      need_in = need_ff;
      seen_in = seen_ff;
      accum_in = accum_ff;
      pre_sep = 1'b0;
      lead_sep = 1'b0;
      cp_valid = 1'b0;
      cp = '0;
      acc_next = {accum_ff[14:0], in_byte[5:0]};
      seen_next = seen_ff + 2'd1;
      if (need_ff != 2'd0 && in_byte[7:6] == 2'b10) begin
         accum_in = acc_next;
         seen_in = seen_next;
         if (seen_next >= need_ff) begin
            cp_valid = 1'b1;
            cp = acc_next;
            need_in = 2'd0;
            seen_in = 2'd0;
            accum_in = '0;
         end
      end else begin
         // A sequence cut short separates, then this byte starts over as a lead byte.
         pre_sep = need_ff != 2'd0;
         need_in = 2'd0;
         seen_in = 2'd0;
         accum_in = '0;
         if (in_byte[7] == 1'b0) begin
            cp_valid = 1'b1;
            cp = {13'd0, in_byte};
         end else if (in_byte[7:5] == 3'b110) begin
            need_in = 2'd1;
            accum_in = {16'd0, in_byte[4:0]};
         end else if (in_byte[7:4] == 4'b1110) begin
            need_in = 2'd2;
            accum_in = {17'd0, in_byte[3:0]};
         end else if (in_byte[7:3] == 5'b11110) begin
            need_in = 2'd3;
            accum_in = {18'd0, in_byte[2:0]};
         end else begin
            lead_sep = 1'b1;
         end
      end
      if (in_final) begin
         need_in = 2'd0;
         seen_in = 2'd0;
         accum_in = '0;
      end
   end

   always_comb begin
      if (cp_valid) act = uft_pkg::classify(cp);
      else if (lead_sep) act = uft_pkg::sep_act();
      else act = '0;
   end

   // The final separator also covers a truncated sequence at end of text.
   always_comb begin
      cmd = '0;
      n = '0;
      open_w = open_ff;
      if (pre_sep && open_w) begin
         cmd.slots[n] = '{data: 8'h00, token_end: 1'b1};
         n = n + 3'd1;
         open_w = 1'b0;
      end
      if (pre_sep) open_w = 1'b0;
      if (act.act == uft_pkg::ActSep) begin
         if (open_w) begin
            cmd.slots[n] = '{data: 8'h00, token_end: 1'b1};
            n = n + 3'd1;
         end
         open_w = 1'b0;
      end else if (act.act == uft_pkg::ActBytes) begin
         for (int i = 0; i < 4; i++) begin
            if (3'(i) < act.count) begin
               cmd.slots[n] = '{data: act.bytes[i], token_end: 1'b0};
               n = n + 3'd1;
            end
         end
         open_w = 1'b1;
      end
      if (in_final) begin
         if (open_w) begin
            cmd.slots[n] = '{data: 8'h00, token_end: 1'b1};
            n = n + 3'd1;
         end
         open_w = 1'b0;
      end
      cmd.count = n;
      open_in = open_w;
   end

   assign push = in_fire && (n != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= 2'd0;
         seen_ff <= 2'd0;
         accum_ff <= '0;
         open_ff <= 1'b0;
      end else if (in_fire) begin
         need_ff <= need_in;
         seen_ff <= seen_in;
         accum_ff <= accum_in;
         open_ff <= open_in;
      end
   end

endmodule

@@ design/uft_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on uft_pkg.
module uft_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  uft_pkg::cmd_type push_cmd,
   output logic full,
   input  logic pop,
   output logic not_empty,
   output uft_pkg::cmd_type head
);

   uft_pkg::cmd_type entry_ff [uft_pkg::QueueDepth];
   logic [uft_pkg::QueuePtrWidth-1:0] wr_ff, wr_in;
   logic [uft_pkg::QueuePtrWidth-1:0] rd_ff, rd_in;
   logic [uft_pkg::QueuePtrWidth:0] cnt_ff, cnt_in;

   assign full = cnt_ff == (uft_pkg::QueuePtrWidth+1)'(uft_pkg::QueueDepth);
   assign not_empty = cnt_ff != '0;
   assign head = entry_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (uft_pkg::QueuePtrWidth+1)'(push) - (uft_pkg::QueuePtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_cmd;
   end

endmodule

@@ design/uft_back.sv @@
// Back end: walks the head command's results, one per cycle while rsp_ch is not
// stalled, into the output register. Depends on uft_pkg and uft_rsp_if.
module uft_back (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   input  uft_pkg::cmd_type cmd,
   output logic pop,
   uft_rsp_if.source rsp_ch
);

   logic [uft_pkg::SlotIdxWidth-1:0] idx_ff, idx_in;
   logic valid_ff, valid_in;
   logic [7:0] data_ff;
   logic end_ff;
   logic last_ff;
   logic take, last;
   uft_pkg::slot_type slot;

   assign take = cmd_valid && (!valid_ff || rsp_ch.ready);
   assign slot = cmd.slots[idx_ff];
   assign last = idx_ff == (cmd.count - 3'd1);
   assign pop = take && last;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = last ? '0 : idx_ff + 3'd1;
      valid_in = valid_ff;
      if (take) valid_in = 1'b1;
      else if (rsp_ch.ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= slot.data;
         end_ff <= slot.token_end;
         last_ff <= last;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.folded_byte = data_ff;
   assign rsp_ch.token_end = end_ff;
   assign rsp_ch.run_last = last_ff;

endmodule

@@ design/utf8_fold_tokenizer_core.sv @@
// Top level of the UTF-8 fold tokenizer: front end, command queue, back end.
// Depends on uft_pkg, uft_req_if, uft_rsp_if, uft_front, uft_queue, uft_back.
//
//   Channel   Direction  Payload                           Handshake
//   req_ch    in         text_byte[7:0], final_byte        valid/ready
//   rsp_ch    out        folded_byte[7:0], token_end,      valid/ready
//                        run_last
//
// The front end decodes and classifies one byte per cycle unless the queue is full and
// queues its result list. The back end sends one result per cycle while rsp_ch is ready
// and stays on an item until all its results are sent; items with no result never reach
// it. The two-entry queue stalls the input only when the back end falls behind.
// Reset is synchronous; no clearing pass is needed.
module utf8_fold_tokenizer_core (
   input  logic clock,
   input  logic reset,
   uft_req_if.sink req_ch,
   uft_rsp_if.source rsp_ch
);

   logic in_fire;
   logic push, full, pop, not_empty;
   uft_pkg::cmd_type push_cmd;
   uft_pkg::cmd_type head;

   assign req_ch.ready = !full;
   assign in_fire = req_ch.valid && !full;

   uft_front u_front (
      .clock(clock),
      .reset(reset),
      .in_fire(in_fire),
      .in_byte(req_ch.text_byte),
      .in_final(req_ch.final_byte),
      .push(push),
      .cmd(push_cmd)
   );

   uft_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .full(full),
      .pop(pop),
      .not_empty(not_empty),
      .head(head)
   );

   uft_back u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(not_empty),
      .cmd(head),
      .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule
